FILE: rtl/slrg_pkg.sv
// ----------------------------------------------------------------------------
// slrg_pkg - shared definitions for the shuffled Lehmer generator
// Item types, Lehmer constants, control word layout and the microcode
// program that sequences the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package slrg_pkg;

	// Lehmer generator constants
	localparam int          TABLE_DEPTH_DEF = 32;
	localparam logic [31:0] LEH_MOD         = 32'h7FFF_FFFF;
	localparam logic [15:0] LEH_MUL         = 16'd16807;
	localparam logic [23:0] FRAC_CAP        = 24'd16777214;

	// Channel items
	typedef struct packed {
		logic               op;
		logic signed [31:0] seed_value;
	} in_item_t;

	typedef struct packed {
		logic [30:0] raw_value;
		logic [23:0] fraction;
		logic [30:0] state_out;
	} out_item_t;

	// Operation codes of the input item
	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// Working register source select
	localparam logic [1:0] X_HOLD = 2'd0;
	localparam logic [1:0] X_LOAD = 2'd1;
	localparam logic [1:0] X_INIT = 2'd2;
	localparam logic [1:0] X_RED  = 2'd3;

	// Multiplier operand select
	localparam logic [1:0] MUL_LEH = 2'd0;
	localparam logic [1:0] MUL_RCP = 2'd1;
	localparam logic [1:0] MUL_REM = 2'd2;

	// Jump conditions
	localparam logic [1:0] J_NEXT     = 2'd0;
	localparam logic [1:0] J_GOTO     = 2'd1;
	localparam logic [1:0] J_NORESEED = 2'd2;
	localparam logic [1:0] J_CNT_NZ   = 2'd3;

	// Microprogram step addresses
	localparam int UPC_W = 4;
	localparam logic [UPC_W-1:0] S_IDLE  = 4'd0;
	localparam logic [UPC_W-1:0] S_CHECK = 4'd1;
	localparam logic [UPC_W-1:0] S_INIT  = 4'd2;
	localparam logic [UPC_W-1:0] S_FMUL  = 4'd3;
	localparam logic [UPC_W-1:0] S_FRED  = 4'd4;
	localparam logic [UPC_W-1:0] S_LAST  = 4'd5;
	localparam logic [UPC_W-1:0] S_DRAW  = 4'd6;
	localparam logic [UPC_W-1:0] S_DRED  = 4'd7;
	localparam logic [UPC_W-1:0] S_QEST  = 4'd8;
	localparam logic [UPC_W-1:0] S_QMUL  = 4'd9;
	localparam logic [UPC_W-1:0] S_QFIX  = 4'd10;
	localparam logic [UPC_W-1:0] S_READ  = 4'd11;
	localparam logic [UPC_W-1:0] S_EMIT  = 4'd12;

	// One control word per step
	typedef struct packed {
		logic [UPC_W-1:0] target;
		logic [1:0]       jmp;
		logic             take;
		logic [1:0]       x_sel;
		logic             mul_en;
		logic [1:0]       mul_sel;
		logic             cnt_load;
		logic             fill;
		logic             last_ld;
		logic             q_est;
		logic             q_fix;
		logic             tab_rd;
		logic             emit;
	} ucode_t;

	// Status fed back from the datapath
	typedef struct packed {
		logic reseed;
		logic cnt_nz;
		logic out_busy;
	} stat_t;

	// Microcode store
	function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
		ucode_t cw;
		cw     = '0;
		cw.jmp = J_NEXT;
		case (addr)
			// wait for an item, capture it
			S_IDLE: begin
				cw.take  = 1'b1;
				cw.x_sel = X_LOAD;
			end
			// skip the table fill unless a re-seed is due
			S_CHECK: begin
				cw.jmp    = J_NORESEED;
				cw.target = S_DRAW;
			end
			S_INIT: begin
				cw.x_sel    = X_INIT;
				cw.cnt_load = 1'b1;
			end
			S_FMUL: begin
				cw.mul_en  = 1'b1;
				cw.mul_sel = MUL_LEH;
			end
			S_FRED: begin
				cw.x_sel  = X_RED;
				cw.fill   = 1'b1;
				cw.jmp    = J_CNT_NZ;
				cw.target = S_FMUL;
			end
			S_LAST: begin
				cw.last_ld = 1'b1;
			end
			S_DRAW: begin
				cw.mul_en  = 1'b1;
				cw.mul_sel = MUL_LEH;
			end
			S_DRED: begin
				cw.x_sel   = X_RED;
				cw.mul_en  = 1'b1;
				cw.mul_sel = MUL_RCP;
			end
			S_QEST: begin
				cw.q_est = 1'b1;
			end
			S_QMUL: begin
				cw.mul_en  = 1'b1;
				cw.mul_sel = MUL_REM;
			end
			S_QFIX: begin
				cw.q_fix = 1'b1;
			end
			S_READ: begin
				cw.tab_rd = 1'b1;
			end
			S_EMIT: begin
				cw.emit   = 1'b1;
				cw.jmp    = J_GOTO;
				cw.target = S_IDLE;
			end
			default: begin
				cw.jmp    = J_GOTO;
				cw.target = S_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/slrg_chan_if.sv
// ----------------------------------------------------------------------------
// slrg_chan_if - valid/ready channel
// Carries one item per handshake; the item type is set per instance.
// ----------------------------------------------------------------------------
`default_nettype none

interface slrg_chan_if #(
	parameter type item_t = logic
) ();
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/slrg_useq.sv
// ----------------------------------------------------------------------------
// slrg_useq - microcode sequencer
// Step counter, control store fetch and conditional jumps. Stalls on an
// empty input channel or a full output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slrg_useq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  slrg_pkg::stat_t  stat,
	output slrg_pkg::ucode_t cw,
	output logic             run
);
	import slrg_pkg::*;

	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] upc_nxt;

	// Fetch the control word of the current step
	assign cw  = ucode_rom(upc_q);
	assign run = !((cw.take && !cmd_valid) || (cw.emit && stat.out_busy));

	// Pick the next step
	always_comb begin
		case (cw.jmp)
			J_NEXT:     upc_nxt = upc_q + 1'b1;
			J_GOTO:     upc_nxt = cw.target;
			J_NORESEED: upc_nxt = stat.reseed ? upc_q + 1'b1 : cw.target;
			J_CNT_NZ:   upc_nxt = stat.cnt_nz ? cw.target : upc_q + 1'b1;
			default:    upc_nxt = S_IDLE;
		endcase
	end

	// Advance, or hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else if (run) begin
			upc_q <= upc_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/slrg_dpath.sv
// ----------------------------------------------------------------------------
// slrg_dpath - generator datapath
// Shared multiplier with a registered product, modular reduction, index
// division by reciprocal, shuffle table memory and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slrg_dpath #(
	parameter int TABLE_DEPTH = slrg_pkg::TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  slrg_pkg::ucode_t    cw,
	input  logic                run,
	input  slrg_pkg::in_item_t  cmd_item,
	input  logic                res_ready,
	output logic                res_valid,
	output slrg_pkg::out_item_t res_item,
	output slrg_pkg::stat_t     stat
);
	import slrg_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int QW    = $clog2(TABLE_DEPTH) + 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 8);
	// Bucket width of the index division and its reciprocal (scaled by 2^31)
	localparam logic [31:0] DIV = 32'd1 + (LEH_MOD - 32'd1) / TABLE_DEPTH;
	localparam logic [63:0] RCP_FULL = 64'h8000_0000 / {32'd0, DIV};
	localparam logic [15:0] RCP = RCP_FULL[15:0];

	// Architectural state
	logic [30:0] lehmer_q;
	logic [30:0] last_q;
	logic [30:0] tab_mem [TABLE_DEPTH];

	// Working registers
	logic [31:0]      x_q;
	logic [31:0]      seed_q;
	logic             neg_q;
	logic             reseed_q;
	logic [CNT_W-1:0] cnt_q;
	logic [QW-1:0]    q_q;
	logic [IDX_W-1:0] idx_q;
	logic [30:0]      rd_q;
	logic [47:0]      prod_s1;
	logic             out_valid_q;
	out_item_t        res_q;

	// Combinational
	logic [31:0]      mul_a;
	logic [15:0]      mul_b;
	logic [31:0]      red_sum;
	logic [31:0]      red_val;
	logic [30:0]      red31;
	logic [31:0]      seed_u;
	logic             ld_nonpos;
	logic [30:0]      rem;
	logic [QW:0]      q_fixed;
	logic             fill_wr;
	logic [23:0]      frac_t;
	logic [31:0]      frac_sum;
	logic [24:0]      frac_q;
	logic [23:0]      frac;

	assign seed_u    = $unsigned(cmd_item.seed_value);
	assign ld_nonpos = seed_u[31] || (seed_u == 32'd0);

	// Multiplier operand select
	always_comb begin
		case (cw.mul_sel)
			MUL_LEH: begin
				mul_a = x_q;
				mul_b = LEH_MUL;
			end
			MUL_RCP: begin
				mul_a = {1'b0, last_q};
				mul_b = RCP;
			end
			MUL_REM: begin
				mul_a = DIV;
				mul_b = 16'(q_q);
			end
			default: begin
				mul_a = x_q;
				mul_b = LEH_MUL;
			end
		endcase
	end

	// Register the product
	always_ff @(posedge clk) begin
		if (run && cw.mul_en) begin
			prod_s1 <= {16'd0, mul_a} * {32'd0, mul_b};
		end
	end

	// Reduce mod 2^31-1: fold the high part onto the low part, one subtract
	always_comb begin
		red_sum = {1'b0, prod_s1[30:0]} + {15'd0, prod_s1[47:31]};
		red_val = (red_sum >= LEH_MOD) ? (red_sum - LEH_MOD) : red_sum;
		red31   = red_val[30:0];
	end

	// Correct the reciprocal estimate by one, then saturate
	always_comb begin
		rem     = last_q - prod_s1[30:0];
		q_fixed = {1'b0, q_q} + {{QW{1'b0}}, (rem >= DIV[30:0])};
	end

	// Working value, captured item, loop counter, quotient estimate and table index
	always_ff @(posedge clk) begin
		if (run) begin
			case (cw.x_sel)
				X_LOAD:  x_q <= (cmd_item.op == OP_LOAD) ? seed_u : {1'b0, lehmer_q};
				X_INIT:  x_q <= neg_q ? (~seed_q + 32'd1) : 32'd1;
				X_RED:   x_q <= {1'b0, red31};
				default: x_q <= x_q;
			endcase
			if (cw.take) begin
				seed_q   <= seed_u;
				neg_q    <= (cmd_item.op == OP_LOAD) && seed_u[31];
				reseed_q <= ((cmd_item.op == OP_LOAD) ? ld_nonpos : (lehmer_q == 31'd0))
					|| (last_q == 31'd0);
			end
			if (cw.cnt_load) begin
				cnt_q <= CNT_W'(TABLE_DEPTH + 7);
			end else if (cw.fill && (cnt_q != '0)) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cw.q_est) begin
				q_q <= prod_s1[31 +: QW];
			end
			if (cw.q_fix) begin
				idx_q <= (q_fixed >= (QW+1)'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1)
					: q_fixed[IDX_W-1:0];
			end
		end
	end

	// Shuffle table: fill during re-seed, swap on emit
	assign fill_wr = cw.fill && (cnt_q < CNT_W'(TABLE_DEPTH));

	always_ff @(posedge clk) begin
		if (run && fill_wr) begin
			tab_mem[cnt_q[IDX_W-1:0]] <= red31;
		end else if (run && cw.emit) begin
			tab_mem[idx_q] <= x_q[30:0];
		end
		if (run && cw.tab_rd) begin
			rd_q <= tab_mem[idx_q];
		end
	end

	// Q0.24 fraction: divide by 2^31-1 as shift plus one-step correction
	always_comb begin
		frac_t   = rd_q[30:7];
		frac_sum = {8'd0, frac_t} + {1'b0, rd_q[6:0], 24'd0};
		frac_q   = {1'b0, frac_t} + {24'd0, (frac_sum >= LEH_MOD)};
		frac     = (frac_q > {1'b0, FRAC_CAP}) ? FRAC_CAP : frac_q[23:0];
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (run && cw.emit) begin
			res_q.raw_value <= rd_q;
			res_q.fraction  <= frac;
			res_q.state_out <= x_q[30:0];
		end
	end

	// Generator state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lehmer_q    <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (run && cw.last_ld) begin
				last_q <= x_q[30:0];
			end
			if (run && cw.emit) begin
				last_q      <= rd_q;
				lehmer_q    <= x_q[30:0];
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid     = out_valid_q;
	assign res_item      = res_q;
	assign stat.reseed   = reseed_q;
	assign stat.cnt_nz   = (cnt_q != '0);
	assign stat.out_busy = out_valid_q && !res_ready;

endmodule

`default_nettype wire

FILE: rtl/shuffled_lehmer_random_generator_core.sv
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator_core - shuffled Lehmer uniform generator
// Minimal standard multiplicative generator behind a shuffle table.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one item per draw: op selects drawing from the kept state
//   or loading seed_value first. res returns one item per cmd item: the
//   shuffled integer, its Q0.24 fraction and the updated Lehmer state.
//   Items are handled one at a time by a microcoded sequencer.
//   The next item can be accepted in the cycle after a plain draw has
//   reached the result register. The shared multiplier is the limit:
//   it is used three times per draw (Lehmer step, index reciprocal,
//   index remainder). A re-seed adds TABLE_DEPTH+8 Lehmer steps, each
//   through the multiplier and then the reducer.
//   Reset clears the Lehmer state and the last output, so the first item
//   after reset always re-seeds; the table is written before it is read.
//   The result register lets a new item be accepted while a result waits;
//   if the receiver stalls, the sequencer holds at its final step until
//   the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module shuffled_lehmer_random_generator_core #(
	parameter int TABLE_DEPTH = slrg_pkg::TABLE_DEPTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	slrg_chan_if.sink   cmd,
	slrg_chan_if.source res
);
	import slrg_pkg::*;

	ucode_t    cw;
	stat_t     stat;
	logic      run;
	logic      res_valid;
	out_item_t res_item;

	// Sequencer
	slrg_useq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.stat      (stat),
		.cw        (cw),
		.run       (run)
	);

	// Datapath
	slrg_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cw        (cw),
		.run       (run),
		.cmd_item  (cmd.payload),
		.res_ready (res.ready),
		.res_valid (res_valid),
		.res_item  (res_item),
		.stat      (stat)
	);

	assign cmd.ready   = cw.take;
	assign res.valid   = res_valid;
	assign res.payload = res_item;

endmodule

`default_nettype wire

FILE: rtl/slrg_checker.sv
// ----------------------------------------------------------------------------
// slrg_checker - port-level checks for the generator core
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module slrg_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_ready,
	input logic                res_valid,
	input logic                res_ready,
	input slrg_pkg::out_item_t res_payload
);
	import slrg_pkg::*;

	// Hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_payload))
		else $error("result changed while stalled");

	// One item in flight: no acceptance right after an acceptance
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("item accepted while another is in work");

	// Results stay below the modulus and the fraction under its cap
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_payload.fraction <= FRAC_CAP)
			&& (res_payload.raw_value != LEH_MOD[30:0])
			&& (res_payload.state_out != LEH_MOD[30:0]))
		else $error("result out of range");

endmodule

bind shuffled_lehmer_random_generator_core slrg_checker u_slrg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_payload (res.payload)
);

`default_nettype wire

FILE: tb/shuffled_lehmer_random_generator_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator_core_test - self-checking bench
// Sends draw and seed-load items, works out the expected integer, fraction
// and Lehmer state of every item with a local model of the shuffled
// generator, and compares each result as it leaves the block. Both sides
// idle and stall at random, with a long receiver hold-off and a full pause
// of the sender.
// ----------------------------------------------------------------------------
module shuffled_lehmer_random_generator_core_test;
	import slrg_pkg::*;

	localparam int          DEPTH       = TABLE_DEPTH_DEF;
	localparam logic [31:0] IDX_DIV     = 32'd1 + (LEH_MOD - 32'd1) / DEPTH;
	localparam int          PHASE_ITEMS = 210;
	localparam int          HOLD_ITEMS  = 40;
	localparam int          LONG_HOLD   = 400;
	localparam int          TAIL_CYCLES = 200;
	localparam int          MAX_PRINTS  = 50;
	// timeout in ns; the clock period is 4 ns
	localparam longint      TIMEOUT_NS  = 64'd4_000_000;

	logic clk = 1'b0;
	logic arst_n;
	logic recv_hold = 1'b0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int n_errors       = 0;
	int n_results      = 0;
	int n_loads        = 0;
	int n_reseeds      = 0;
	int n_dead_states  = 0;

	in_item_t  pending_items[$];
	out_item_t expected_draws[$];

	// Local copy of the generator state
	logic [30:0] gen_state;
	logic [30:0] gen_last;
	logic [30:0] shuffle[DEPTH];

	event long_hold_ev;

	slrg_chan_if #(.item_t(in_item_t))  cmd_ch ();
	slrg_chan_if #(.item_t(out_item_t)) res_ch ();

	shuffled_lehmer_random_generator_core #(.TABLE_DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Exact x * 16807 mod (2^31 - 1)
	function automatic logic [31:0] lehmer_mul(input logic [31:0] x);
		logic [63:0] p;
		p = {32'd0, x} * {48'd0, LEH_MUL};
		return 32'(p % {32'd0, LEH_MOD});
	endfunction

	// Advance the local generator by one item and queue the result it gives
	task automatic predict_draw(input in_item_t it);
		logic [31:0] sbits;
		logic [31:0] x;
		logic [31:0] idx;
		logic [63:0] frac;
		logic        neg;
		logic        nonpos;
		out_item_t   r;
		int          j;
		sbits = it.seed_value;
		if (it.op == OP_LOAD) begin
			neg    = sbits[31];
			nonpos = neg || (sbits == 32'd0);
			x      = sbits;
			n_loads++;
		end else begin
			neg    = 1'b0;
			x      = {1'b0, gen_state};
			nonpos = (x == 32'd0);
		end
		// re-seed: warm up, then fill the shuffle from the last DEPTH steps
		if (nonpos || gen_last == 31'd0) begin
			n_reseeds++;
			x = neg ? (~sbits + 32'd1) : 32'd1;
			for (j = DEPTH + 7; j >= 0; j--) begin
				x = lehmer_mul(x);
				if (j < DEPTH)
					shuffle[j] = x[30:0];
			end
			gen_last = shuffle[0];
		end
		// step once, swap the new state into the selected slot
		x   = lehmer_mul(x);
		idx = {1'b0, gen_last} / IDX_DIV;
		if (idx >= 32'(DEPTH))
			idx = 32'(DEPTH - 1);
		gen_last     = shuffle[idx];
		shuffle[idx] = x[30:0];
		gen_state    = x[30:0];
		frac = ({33'd0, gen_last} << 24) / {32'd0, LEH_MOD};
		if (frac > {40'd0, FRAC_CAP})
			frac = {40'd0, FRAC_CAP};
		r.raw_value = gen_last;
		r.fraction  = frac[23:0];
		r.state_out = gen_state;
		if (gen_state == 31'd0)
			n_dead_states++;
		expected_draws.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (n_errors < MAX_PRINTS)
			$display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		n_errors++;
	endtask

	task automatic queue_item(input logic op, input logic [31:0] seed);
		in_item_t it;
		it.op         = op;
		it.seed_value = seed;
		pending_items.push_back(it);
	endtask

	// Mostly draws, some loads, a few awkward seeds
	task automatic queue_random_item();
		int pick;
		pick = $urandom_range(99);
		if (pick < 78)
			queue_item(OP_DRAW, $urandom);
		else if (pick < 84)
			queue_item(OP_LOAD, $urandom_range(32'h7FFF_FFFE, 1));
		else if (pick < 88)
			queue_item(OP_LOAD, $urandom_range(1000, 1));
		else if (pick < 95)
			queue_item(OP_LOAD, {1'b1, 31'($urandom)});
		else
			case ($urandom_range(5))
				0: queue_item(OP_LOAD, 32'h0000_0000);
				1: queue_item(OP_LOAD, 32'h7FFF_FFFF);
				2: queue_item(OP_LOAD, 32'h8000_0000);
				3: queue_item(OP_LOAD, 32'h8000_0001);
				4: queue_item(OP_LOAD, 32'hFFFF_FFFF);
				default: queue_item(OP_LOAD, 32'h0000_0001);
			endcase
	endtask

	// Wait until every item is sent and every result has come back
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || cmd_ch.valid || expected_draws.size() != 0);
	endtask

	// Command driver: predict on acceptance, then offer the next item
	always @(posedge clk or negedge arst_n) begin : cmd_drive
		logic offer;
		if (!arst_n) begin
			cmd_ch.valid   <= 1'b0;
			cmd_ch.payload <= '0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready)
				predict_draw(cmd_ch.payload);
			if (!cmd_ch.valid || cmd_ch.ready) begin
				offer = (pending_items.size() != 0) &&
					($urandom_range(99) >= send_idle_pct);
				if (offer) begin
					cmd_ch.valid   <= 1'b1;
					cmd_ch.payload <= pending_items.pop_front();
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: random stalls, or hold off entirely
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else
			res_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
	end

	// Long receiver hold-off, counted here
	initial begin
		forever begin
			@(long_hold_ev);
			recv_hold <= 1'b1;
			repeat (LONG_HOLD) @(posedge clk);
			recv_hold <= 1'b0;
		end
	end

	// Result monitor: compare against the oldest expectation
	always @(posedge clk) begin : res_check
		out_item_t got;
		out_item_t want;
		if (arst_n === 1'b1 && res_ch.valid && res_ch.ready) begin
			got = res_ch.payload;
			n_results++;
			if (expected_draws.size() == 0) begin
				report_mismatch("unexpected result raw_value", got.raw_value, 0);
			end else begin
				want = expected_draws.pop_front();
				if (got.raw_value !== want.raw_value)
					report_mismatch("raw_value", got.raw_value, want.raw_value);
				if (got.fraction !== want.fraction)
					report_mismatch("fraction", got.fraction, want.fraction);
				if (got.state_out !== want.state_out)
					report_mismatch("state_out", got.state_out, want.state_out);
			end
		end
	end

	// Hard stop
	initial begin
		#(TIMEOUT_NS);
		$display("%0t: timeout with %0d results outstanding", $time, expected_draws.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// Main sequence
	initial begin : main_seq
		int send_pcts[4];
		int recv_pcts[4];
		int p;
		int i;
		send_pcts = '{0, 54, 0, 14};
		recv_pcts = '{0, 0, 54, 14};
		gen_state = '0;
		gen_last  = '0;
		for (i = 0; i < DEPTH; i++)
			shuffle[i] = '0;

		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: first draw re-seeds, seed extremes, zero-state cases
		queue_item(OP_DRAW, 32'hFFFF_FFFF);
		queue_item(OP_DRAW, 32'h0000_0000);
		queue_item(OP_LOAD, 32'h0000_0001);
		queue_item(OP_LOAD, 32'h7FFF_FFFE);
		queue_item(OP_LOAD, 32'h7FFF_FFFF);
		queue_item(OP_DRAW, 32'h0000_0000);
		queue_item(OP_DRAW, 32'h1234_5678);
		queue_item(OP_LOAD, 32'h8000_0001);
		queue_item(OP_DRAW, 32'h0000_0000);
		queue_item(OP_LOAD, 32'h8000_0001);
		queue_item(OP_LOAD, 32'h0000_3039);
		queue_item(OP_LOAD, 32'h8000_0000);
		queue_item(OP_DRAW, 32'h5555_5555);
		queue_item(OP_LOAD, 32'h0000_0000);
		queue_item(OP_LOAD, 32'hFFFF_FFFF);
		queue_item(OP_LOAD, 32'hAAAA_AAAA);
		queue_item(OP_LOAD, 32'h5555_5555);
		queue_item(OP_DRAW, 32'hAAAA_AAAA);
		queue_item(OP_DRAW, 32'h7FFF_FFFF);
		queue_item(OP_DRAW, 32'h8000_0000);
		wait_idle();

		// Random phases under different idling mixes
		for (p = 0; p < 4; p++) begin
			send_idle_pct  = send_pcts[p];
			recv_stall_pct = recv_pcts[p];
			for (i = 0; i < PHASE_ITEMS; i++) begin
				queue_random_item();
				// let the sender run dry once mid-phase
				if (p == 1 && i == PHASE_ITEMS / 2)
					wait_idle();
			end
			wait_idle();
		end

		// Hold off the receiver while the sender keeps offering
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		for (i = 0; i < HOLD_ITEMS; i++)
			queue_random_item();
		-> long_hold_ev;
		wait_idle();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d results from %0d seed loads and %0d table re-seeds.",
			n_results, n_loads, n_reseeds);
		$display("Zero states hit: %0d; idling mixes, a %0d-cycle hold-off and a drain pause.",
			n_dead_states, LONG_HOLD);
		if (n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/slrg_pkg.sv
rtl/slrg_chan_if.sv
rtl/slrg_useq.sv
rtl/slrg_dpath.sv
rtl/shuffled_lehmer_random_generator_core.sv
rtl/slrg_checker.sv
tb/shuffled_lehmer_random_generator_core_test.sv
